>>> rtl/core/mwc_pkg.sv
package mwc_pkg;

    // recurrence and mixing multipliers
    localparam logic [31:0] MWC_MULT  = 32'd4294095429;
    localparam logic [31:0] MIX_HI    = 32'd4078645709;
    localparam logic [31:0] MIX_LO    = 32'd3580663381;

    // seed mixing constants
    localparam logic [31:0] SEED_K1   = 32'd3571494541;
    localparam logic [31:0] SEED_K2   = 32'd3753453877;
    localparam logic [63:0] SEED_K3   = 64'd18277323205306182053;
    localparam logic [63:0] SEED_MASK = 64'h3FFFFFFF7FFFFFFF;

    // offset added to the seed products, and the state used when the mix masks to zero
    localparam logic [63:0] SEED_ADD  = SEED_K3 + {32'd0, SEED_K1};
    localparam logic [63:0] SEED_ALT  = (SEED_K3 + {32'd0, SEED_K2}) & SEED_MASK;

    // discarded steps after a reseed
    localparam int WARMUP = 11;
    localparam int WARM_W = $clog2(WARMUP);

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // operation codes carried through the queue
    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_SEED = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // one queued request: operation and its 64-bit operand
    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] operand;
    } mwc_entry_t;

endpackage

>>> rtl/core/mwc_front.sv
module mwc_front
    import mwc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [63:0] seed,
    input  logic [63:0] load_value,
    output logic        q_valid,
    input  logic        q_ready,
    output mwc_entry_t  q_entry
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // request codes as they arrive on the stream
    localparam logic [1:0] REQ_DRAW = 2'd0;
    localparam logic [1:0] REQ_SEED = 2'd1;
    localparam logic [1:0] REQ_LOAD = 2'd2;

    mwc_entry_t             queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   push;
    logic                   pop;
    mwc_entry_t             decoded;

    // classify the request and keep only the operand it needs
    always_comb
    begin
        decoded.operand = '0;
        unique case (req_type)
            REQ_DRAW:
            begin
                decoded.op = OP_DRAW;
            end
            REQ_SEED:
            begin
                decoded.op      = OP_SEED;
                decoded.operand = seed;
            end
            REQ_LOAD:
            begin
                decoded.op      = OP_LOAD;
                decoded.operand = load_value;
            end
            default:
            begin
                decoded.op = OP_NONE;
            end
        endcase
    end

    // queue handshake
    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_entry  = queue_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

>>> rtl/core/mwc_back.sv
module mwc_back
    import mwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  mwc_entry_t  q_entry,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_value,
    output logic [63:0] out_state
);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_STEP  = 4'd1;
    localparam logic [3:0] ST_MIXH  = 4'd2;
    localparam logic [3:0] ST_MIXL  = 4'd3;
    localparam logic [3:0] ST_SEED0 = 4'd4;
    localparam logic [3:0] ST_SEED1 = 4'd5;
    localparam logic [3:0] ST_SEED2 = 4'd6;
    localparam logic [3:0] ST_SEED3 = 4'd7;
    localparam logic [3:0] ST_MASK  = 4'd8;
    localparam logic [3:0] ST_WARM  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0]        fsm_reg;
    logic [3:0]        fsm_next;
    logic [63:0]       gen_reg;
    logic [63:0]       gen_next;
    logic [63:0]       acc_reg;
    logic [63:0]       acc_next;
    logic [63:0]       val_reg;
    logic [63:0]       val_next;
    logic [63:0]       opnd_reg;
    logic [63:0]       opnd_next;
    logic [WARM_W-1:0] warm_reg;
    logic [WARM_W-1:0] warm_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [63:0]       out_value_reg;
    logic [63:0]       out_state_reg;
    logic              out_load;

    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       mul_p;
    logic [63:0]       step_sum;
    logic [63:0]       masked;

    // shared 32x32 multiplier, operands picked by the sequencer
    always_comb
    begin
        mul_a = gen_reg[31:0];
        mul_b = MWC_MULT;
        unique case (fsm_reg)
            ST_MIXH:
            begin
                mul_a = gen_reg[63:32];
                mul_b = MIX_HI;
            end
            ST_MIXL:
            begin
                mul_a = gen_reg[31:0];
                mul_b = MIX_LO;
            end
            ST_SEED0:
            begin
                mul_a = opnd_reg[31:0];
                mul_b = SEED_K1;
            end
            ST_SEED1:
            begin
                mul_a = opnd_reg[63:32];
                mul_b = SEED_K1;
            end
            ST_SEED2:
            begin
                mul_a = opnd_reg[31:0];
                mul_b = SEED_K2;
            end
            ST_SEED3:
            begin
                mul_a = opnd_reg[63:32];
                mul_b = SEED_K2;
            end
            default:
            begin
                mul_a = gen_reg[31:0];
                mul_b = MWC_MULT;
            end
        endcase
    end

    assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
    assign step_sum = mul_p + {32'd0, gen_reg[63:32]};
    assign masked   = acc_reg & SEED_MASK;

    assign q_ready  = (fsm_reg == ST_IDLE);
    assign out_load = (fsm_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        fsm_next  = fsm_reg;
        gen_next  = gen_reg;
        acc_next  = acc_reg;
        val_next  = val_reg;
        opnd_next = opnd_reg;
        warm_next = warm_reg;
        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    val_next  = '0;
                    opnd_next = q_entry.operand;
                    unique case (q_entry.op)
                        OP_DRAW:
                        begin
                            fsm_next = ST_STEP;
                        end
                        OP_SEED:
                        begin
                            fsm_next = ST_SEED0;
                        end
                        OP_LOAD:
                        begin
                            gen_next = q_entry.operand;
                            fsm_next = ST_DONE;
                        end
                        default:
                        begin
                            fsm_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                gen_next = step_sum;
                fsm_next = ST_MIXH;
            end
            ST_MIXH:
            begin
                acc_next = mul_p;
                fsm_next = ST_MIXL;
            end
            ST_MIXL:
            begin
                val_next = acc_reg + {mul_p[31:0], mul_p[63:32]};
                fsm_next = ST_DONE;
            end
            // seed times each constant, built from 32-bit partial products
            ST_SEED0:
            begin
                acc_next = mul_p + SEED_ADD;
                fsm_next = ST_SEED1;
            end
            ST_SEED1:
            begin
                acc_next = acc_reg + {mul_p[31:0], 32'd0};
                fsm_next = ST_SEED2;
            end
            ST_SEED2:
            begin
                acc_next = acc_reg + mul_p;
                fsm_next = ST_SEED3;
            end
            ST_SEED3:
            begin
                acc_next = acc_reg + {mul_p[31:0], 32'd0};
                fsm_next = ST_MASK;
            end
            ST_MASK:
            begin
                gen_next  = (masked == '0) ? SEED_ALT : masked;
                warm_next = WARM_W'(WARMUP - 1);
                fsm_next  = ST_WARM;
            end
            ST_WARM:
            begin
                gen_next = step_sum;
                if (warm_reg == '0)
                begin
                    fsm_next = ST_DONE;
                end
                else
                begin
                    warm_next = warm_reg - 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    fsm_next = ST_IDLE;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    // output slot handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= ST_IDLE;
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            gen_reg       <= gen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        val_reg  <= val_next;
        opnd_reg <= opnd_next;
        warm_reg <= warm_next;
        if (out_load)
        begin
            out_value_reg <= val_reg;
            out_state_reg <= gen_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_state = out_state_reg;

endmodule

>>> rtl/core/mwc_random_generator_top.sv
// Multiply-with-carry random generator with a 64-bit mixed output. Each request beat on
// s_axis gives exactly one result beat on m_axis, in order. A request is decoded and held
// in a small queue (QUEUE_DEPTH entries) so the input side keeps taking beats while the
// generator works; one 32x32 multiplier is shared by every product, so the steps run in turn:
// a draw runs a recurrence step and two mix products, a load or an unused code goes straight
// to the result, and a reseed runs four seed products, a mask step and 11 warm-up steps.
// The result slot frees the generator to start the next request while a beat waits.
// After reset the state is zero, which the recurrence never leaves, so reseed or load
// the generator before drawing. The upper 32 bits of value serve as a 32-bit output.
module mwc_random_generator_top
    import mwc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // seed [63:0], load_value [127:64]
    input  logic [1:0]   s_axis_tuser,   // req_type [1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // value [63:0], state_now [127:64]
);

    logic        q_valid;
    logic        q_ready;
    mwc_entry_t  q_entry;
    logic [63:0] out_value;
    logic [63:0] out_state;

    // request decode and queue
    mwc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .req_type   (s_axis_tuser),
        .seed       (s_axis_tdata[63:0]),
        .load_value (s_axis_tdata[127:64]),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_entry    (q_entry)
    );

    // generator engine and result beat
    mwc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_value (out_value),
        .out_state (out_state)
    );

    assign m_axis_tdata = {out_state, out_value};

    // a nonzero draw only comes from a nonzero state, and the step keeps it nonzero
    a_value_needs_state: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[63:0] != 64'd0)) |-> (m_axis_tdata[127:64] != 64'd0))
        else $error("nonzero value reported with zero state");

    // a queued request waiting on the engine must not change
    a_queue_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_ready) |=> (q_valid && $stable(q_entry)))
        else $error("queue head changed while the engine was busy");

endmodule
